// File: rtl/register_file_alu_64bit_defines.svh
// assertion macros for the register file alu checker
`ifndef REGISTER_FILE_ALU_64BIT_DEFINES_SVH
`define REGISTER_FILE_ALU_64BIT_DEFINES_SVH

// implication checked on every rising clock edge outside reset
`define RFA_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rfa check failed");

// next-cycle implication checked outside reset
`define RFA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rfa check failed");

`endif

// File: rtl/rfa_pkg.sv
// shared types and constants for the register file alu
package rfa_pkg;
    localparam logic [3:0] OP_ADD = 4'd0;
    localparam logic [3:0] OP_SUB = 4'd1;
    localparam logic [3:0] OP_MUL = 4'd2;
    localparam logic [3:0] OP_DIV = 4'd3;
    localparam logic [3:0] OP_REM = 4'd4;
    localparam logic [3:0] OP_EQ  = 4'd5;
    localparam logic [3:0] OP_AND = 4'd6;
    localparam logic [3:0] OP_OR  = 4'd7;
    localparam logic [3:0] OP_XOR = 4'd8;
    localparam logic [3:0] OP_SHR = 4'd9;
    localparam logic [3:0] OP_SHL = 4'd10;

    localparam logic [1:0] FAULT_NONE   = 2'd0;
    localparam logic [1:0] FAULT_DIV0   = 2'd1;
    localparam logic [1:0] FAULT_BAD_OP = 2'd2;

    localparam logic [7:0] LOW_NIBBLE  = 8'h0f;
    localparam logic [7:0] HIGH_NIBBLE = 8'hf0;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_EXEC,
        ST_ITER,
        ST_DONE
    } t_state;
endpackage

// File: rtl/rfa_ram.sv
// generic single-port-write, one-read ram with registered read
module rfa_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// File: rtl/register_file_alu_64bit.sv
// register file alu top level: sequencer, register memories and iterative mul/div
// Executes one instruction per transfer against NUM_REGS registers of DATA_WIDTH bits.
// The register file lives in two identical rams (one per operand read port), both
// written by every register write. After reset a clearing pass over NUM_REGS entries
// (rounded up to a power of two) zeroes both rams; no instruction is taken during it.
// The rams are addressed straight from the input payload while idle, so the operands
// are read at the transfer edge. Single-step ops then pass operand capture (ST_READ),
// execute (ST_EXEC) and hand over to the output register (ST_DONE); mul, div and rem
// run a bit-serial unit one bit per cycle (ST_ITER) between execute and hand over.
// Divide, remainder or multiply with a zero right operand skip the bit-serial unit.
// Input ready is held low until the result has been transferred, so a new instruction
// is not taken before the last result has left. One instruction is in flight at a time,
// so the next read always sees the last write.
module register_file_alu_64bit #(
    parameter int NUM_REGS   = 16,
    parameter int DATA_WIDTH = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [3:0]  i_op,
    input  logic        i_immediate,
    input  logic [7:0]  i_reg_pair,
    input  logic [63:0] i_extend,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_wrote,
    output logic [3:0]  o_dest_index,
    output logic [63:0] o_result_value,
    output logic [1:0]  o_fault
);
    localparam int AW = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
    localparam int CW = $clog2(DATA_WIDTH + 1);
    localparam int W  = DATA_WIDTH;

    // sequencer state
    rfa_pkg::t_state r_state, n_state;

    // clearing pass after reset
    logic          r_clr;
    logic [AW:0]   r_clr_cnt;

    // captured instruction
    logic [3:0]    r_op;
    logic          r_imm;
    logic [3:0]    r_dst;
    logic [3:0]    r_src;
    logic [3:0]    r_rsrc;
    logic [W-1:0]  r_ext;

    // operands
    logic [W-1:0]  r_lhs, r_rhs;
    logic [W-1:0]  ram_a_q, ram_b_q;
    logic [AW-1:0] ram_a_addr, ram_b_addr;

    // iterative unit: shift-add multiply, restoring divide
    logic [W-1:0]  r_acc, r_quo, r_mcand;
    logic [CW-1:0] r_iter;

    // result register
    logic          r_out_valid;
    logic          r_wrote;
    logic [3:0]    r_odst;
    logic [W-1:0]  r_res;
    logic [1:0]    r_fault;

    // write port
    logic          we;
    logic [AW-1:0] waddr;
    logic [W-1:0]  wdata;

    logic [W-1:0]  simple_res;
    logic [1:0]    simple_fault;
    logic          simple_ok;
    logic          is_iter_op;
    logic          src_ok, rsrc_ok, dst_ok;
    logic [W+1:0]  div_trial;
    logic [W:0]    div_rem_sh;
    logic [W-1:0]  mul_sum;

    assign src_ok  = ({28'd0, r_src} < 32'(NUM_REGS));
    assign rsrc_ok = ({28'd0, r_rsrc} < 32'(NUM_REGS));
    assign dst_ok  = ({28'd0, r_dst} < 32'(NUM_REGS));

    // while idle the read ports follow the offered payload, so data is ready after transfer
    assign ram_a_addr = (r_state == rfa_pkg::ST_IDLE) ? i_reg_pair[AW-1:0] : r_src[AW-1:0];
    assign ram_b_addr = (r_state == rfa_pkg::ST_IDLE) ? i_extend[AW-1:0] : r_rsrc[AW-1:0];

    // both rams see every write, so they always hold the same registers
    rfa_ram #(.WIDTH(W), .DEPTH(1 << AW)) u_ram_a (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(waddr),
        .i_wdata(wdata),
        .i_raddr(ram_a_addr),
        .o_rdata(ram_a_q)
    );

    rfa_ram #(.WIDTH(W), .DEPTH(1 << AW)) u_ram_b (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(waddr),
        .i_wdata(wdata),
        .i_raddr(ram_b_addr),
        .o_rdata(ram_b_q)
    );

    assign is_iter_op = (r_op == rfa_pkg::OP_MUL) || (r_op == rfa_pkg::OP_DIV)
                     || (r_op == rfa_pkg::OP_REM);

    // single-step ops
    always_comb begin
        simple_res   = '0;
        simple_fault = rfa_pkg::FAULT_NONE;
        simple_ok    = 1'b1;
        case (r_op)
            rfa_pkg::OP_ADD: simple_res = r_lhs + r_rhs;
            rfa_pkg::OP_SUB: simple_res = r_lhs - r_rhs;
            rfa_pkg::OP_EQ:  simple_res = (r_lhs == r_rhs) ? W'(1) : '0;
            rfa_pkg::OP_AND: simple_res = r_lhs & r_rhs;
            rfa_pkg::OP_OR:  simple_res = r_lhs | r_rhs;
            rfa_pkg::OP_XOR: simple_res = r_lhs ^ r_rhs;
            rfa_pkg::OP_SHR: simple_res = (r_rhs >= W'(W)) ? '0 : (r_lhs >> r_rhs);
            rfa_pkg::OP_SHL: simple_res = (r_rhs >= W'(W)) ? '0 : (r_lhs << r_rhs);
            default: begin
                simple_ok    = 1'b0;
                simple_fault = rfa_pkg::FAULT_BAD_OP;
            end
        endcase
    end

    // one restoring divide step: shift in next dividend bit, try subtract
    assign div_rem_sh = {r_acc, r_quo[W-1]};
    assign div_trial  = {1'b0, div_rem_sh} - {2'b00, r_rhs};
    // one msb-first shift-add multiply step
    assign mul_sum    = r_mcand[W-1] ? ((r_acc << 1) + r_lhs) : (r_acc << 1);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            rfa_pkg::ST_IDLE: if (i_valid && o_ready) n_state = rfa_pkg::ST_READ;
            rfa_pkg::ST_READ: n_state = rfa_pkg::ST_EXEC;
            rfa_pkg::ST_EXEC: begin
                if (is_iter_op && r_rhs != '0) n_state = rfa_pkg::ST_ITER;
                else if (!is_iter_op || r_rhs == '0) n_state = rfa_pkg::ST_DONE;
            end
            rfa_pkg::ST_ITER: if (r_iter == CW'(W - 1)) n_state = rfa_pkg::ST_DONE;
            rfa_pkg::ST_DONE: if (!r_out_valid || i_ready) n_state = rfa_pkg::ST_IDLE;
            default: n_state = rfa_pkg::ST_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        o_ready = (r_state == rfa_pkg::ST_IDLE) && !r_clr && !r_out_valid;
        we      = 1'b0;
        waddr   = r_dst[AW-1:0];
        wdata   = r_res;
        if (r_clr) begin
            we    = 1'b1;
            waddr = r_clr_cnt[AW-1:0];
            wdata = '0;
        end else if (r_state == rfa_pkg::ST_DONE && (!r_out_valid || i_ready)) begin
            we = r_wrote;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= rfa_pkg::ST_IDLE;
            r_clr       <= 1'b1;
            r_clr_cnt   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_clr) begin
                r_clr_cnt <= r_clr_cnt + 1'b1;
                if (r_clr_cnt == (AW + 1)'((1 << AW) - 1)) r_clr <= 1'b0;
            end
            if (r_state == rfa_pkg::ST_DONE && (!r_out_valid || i_ready)) begin
                r_out_valid <= 1'b1;
            end else if (o_valid && i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            rfa_pkg::ST_IDLE: begin
                r_op   <= i_op;
                r_imm  <= i_immediate;
                r_dst  <= 4'((i_reg_pair & rfa_pkg::HIGH_NIBBLE) >> 4);
                r_src  <= 4'(i_reg_pair & rfa_pkg::LOW_NIBBLE);
                r_rsrc <= 4'(i_extend[7:0] & rfa_pkg::LOW_NIBBLE);
                r_ext  <= i_extend[W-1:0];
            end
            rfa_pkg::ST_READ: begin
                r_lhs <= src_ok ? ram_a_q : '0;
                r_rhs <= r_imm ? r_ext : (rsrc_ok ? ram_b_q : '0);
            end
            rfa_pkg::ST_EXEC: begin
                r_acc   <= '0;
                r_quo   <= r_lhs;
                // multiply walks the multiplier from its msb
                r_mcand <= r_rhs;
                r_iter  <= '0;
                if (r_op == rfa_pkg::OP_MUL) begin
                    r_fault <= rfa_pkg::FAULT_NONE;
                    r_wrote <= dst_ok;
                    r_res   <= '0;
                end else if (r_op == rfa_pkg::OP_DIV || r_op == rfa_pkg::OP_REM) begin
                    r_wrote <= dst_ok;
                    if (r_rhs == '0) begin
                        r_fault <= rfa_pkg::FAULT_DIV0;
                        r_res   <= (r_op == rfa_pkg::OP_DIV) ? '1 : r_lhs;
                    end else begin
                        r_fault <= rfa_pkg::FAULT_NONE;
                        r_res   <= '0;
                    end
                end else begin
                    r_fault <= simple_fault;
                    r_wrote <= simple_ok && dst_ok;
                    r_res   <= simple_res;
                end
            end
            rfa_pkg::ST_ITER: begin
                r_iter <= r_iter + 1'b1;
                if (r_op == rfa_pkg::OP_MUL) begin
                    // msb-first shift-add
                    r_acc   <= mul_sum;
                    r_mcand <= r_mcand << 1;
                    r_res   <= mul_sum;
                end else begin
                    r_quo <= {r_quo[W-2:0], ~div_trial[W+1]};
                    r_acc <= div_trial[W+1] ? div_rem_sh[W-1:0] : div_trial[W-1:0];
                    if (r_op == rfa_pkg::OP_DIV) r_res <= {r_quo[W-2:0], ~div_trial[W+1]};
                    else r_res <= div_trial[W+1] ? div_rem_sh[W-1:0] : div_trial[W-1:0];
                end
            end
            rfa_pkg::ST_DONE: begin
                if (!r_out_valid || i_ready) begin
                    r_odst  <= r_dst;
                    r_fault <= r_fault;
                end
            end
            default: ;
        endcase
    end

    // result register loads when the sequencer hands over
    logic [W-1:0] r_ores;
    logic         r_owrote;
    logic [1:0]   r_ofault;
    always_ff @(posedge i_clk) begin
        if (r_state == rfa_pkg::ST_DONE && (!r_out_valid || i_ready)) begin
            r_ores   <= r_res;
            r_owrote <= r_wrote;
            r_ofault <= r_fault;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_wrote        = r_owrote;
    assign o_dest_index   = r_odst;
    assign o_result_value = 64'(r_ores);
    assign o_fault        = r_ofault;
endmodule

// File: rtl/rfa_checker.sv
// port-level checker for the register file alu, bound to the top level
`include "register_file_alu_64bit_defines.svh"
module rfa_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_ready,
    input logic        o_valid,
    input logic        i_ready,
    input logic        o_wrote,
    input logic [63:0] o_result_value,
    input logic [1:0]  o_fault
);
    // one instruction in flight: no new transfer while a result waits
    `RFA_ASSERT_IMPL(a_no_accept_pending, i_clk, i_rst_n, o_valid, !o_ready)
    // an unknown opcode never writes and reports zero
    `RFA_ASSERT_IMPL(a_bad_op_quiet, i_clk, i_rst_n, o_valid && o_fault == rfa_pkg::FAULT_BAD_OP,
        !o_wrote && o_result_value == 64'd0)
    // fault code three never appears
    `RFA_ASSERT_IMPL(a_fault_range, i_clk, i_rst_n, o_valid, o_fault != 2'd3)
    // an accepted instruction cannot produce a result the next cycle
    `RFA_ASSERT_NEXT(a_min_latency, i_clk, i_rst_n, i_valid && o_ready, !o_valid)
endmodule

bind register_file_alu_64bit rfa_checker u_rfa_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_valid        (i_valid),
    .o_ready        (o_ready),
    .o_valid        (o_valid),
    .i_ready        (i_ready),
    .o_wrote        (o_wrote),
    .o_result_value (o_result_value),
    .o_fault        (o_fault)
);

// File: verif/tb_top.sv
// self-checking testbench for the register file alu: random and directed instructions
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NREGS       = 16;
    localparam int RAND_ITEMS  = 1700;
    localparam int STALL_LIMIT = 20000;

    // scoreboard: keeps a shadow register file and the queue of expected results
    typedef struct packed {
        logic        wrote;
        logic [3:0]  dest;
        logic [63:0] value;
        logic [1:0]  fault;
    } t_alu_result;

    class alu_scoreboard;
        logic [63:0]  shadow_regs [NREGS];
        t_alu_result  pending_q [$];
        int           errors;

        function new();
            foreach (shadow_regs[i]) shadow_regs[i] = '0;
            errors = 0;
        endfunction

        // compute what one accepted instruction produces and update the shadow file
        function void note_instr(logic [3:0] op, logic imm, logic [7:0] pair,
                                 logic [63:0] ext);
            t_alu_result r;
            logic [63:0] lhs, rhs;
            lhs = shadow_regs[pair[3:0]];
            rhs = imm ? ext : shadow_regs[ext[3:0]];
            r.dest  = pair[7:4];
            r.fault = rfa_pkg::FAULT_NONE;
            r.wrote = 1'b1;
            r.value = '0;
            case (op)
                rfa_pkg::OP_ADD: r.value = lhs + rhs;
                rfa_pkg::OP_SUB: r.value = lhs - rhs;
                rfa_pkg::OP_MUL: r.value = lhs * rhs;
                rfa_pkg::OP_DIV: begin
                    if (rhs == 0) begin
                        r.value = '1;
                        r.fault = rfa_pkg::FAULT_DIV0;
                    end else begin
                        r.value = lhs / rhs;
                    end
                end
                rfa_pkg::OP_REM: begin
                    if (rhs == 0) begin
                        r.value = lhs;
                        r.fault = rfa_pkg::FAULT_DIV0;
                    end else begin
                        r.value = lhs % rhs;
                    end
                end
                rfa_pkg::OP_EQ:  r.value = (lhs == rhs) ? 64'd1 : 64'd0;
                rfa_pkg::OP_AND: r.value = lhs & rhs;
                rfa_pkg::OP_OR:  r.value = lhs | rhs;
                rfa_pkg::OP_XOR: r.value = lhs ^ rhs;
                rfa_pkg::OP_SHR: r.value = (rhs >= 64) ? 64'd0 : lhs >> rhs[5:0];
                rfa_pkg::OP_SHL: r.value = (rhs >= 64) ? 64'd0 : lhs << rhs[5:0];
                default: begin
                    r.wrote = 1'b0;
                    r.fault = rfa_pkg::FAULT_BAD_OP;
                end
            endcase
            if (r.wrote) shadow_regs[r.dest] = r.value;
            pending_q = {pending_q, r};
        endfunction

        task check_result(t_alu_result got);
            t_alu_result exp_r;
            if (pending_q.size() == 0) begin
                report_mismatch("result with nothing pending", 0, 0);
                return;
            end
            exp_r = pending_q.pop_front();
            if (got.wrote !== exp_r.wrote) report_mismatch("wrote", got.wrote, exp_r.wrote);
            if (got.dest !== exp_r.dest) report_mismatch("dest_index", got.dest, exp_r.dest);
            if (got.value !== exp_r.value)
                report_mismatch("result_value", got.value, exp_r.value);
            if (got.fault !== exp_r.fault) report_mismatch("fault", got.fault, exp_r.fault);
        endtask

        task report_mismatch(string what, logic [63:0] got, logic [63:0] exp_v);
            errors++;
            $display("mismatch %s: got %h expected %h at %0t", what, got, exp_v, $time);
        endtask
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [3:0]  in_op = '0;
    logic        in_imm = 1'b0;
    logic [7:0]  in_pair = '0;
    logic [63:0] in_ext = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic        out_wrote;
    logic [3:0]  out_dest;
    logic [63:0] out_value;
    logic [1:0]  out_fault;

    alu_scoreboard sb = new();
    bit  hold_off = 1'b0;
    int  idle_cycles = 0;

    register_file_alu_64bit DUT (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_valid        (in_valid),
        .o_ready        (in_ready),
        .i_op           (in_op),
        .i_immediate    (in_imm),
        .i_reg_pair     (in_pair),
        .i_extend       (in_ext),
        .o_valid        (out_valid),
        .i_ready        (out_ready),
        .o_wrote        (out_wrote),
        .o_dest_index   (out_dest),
        .o_result_value (out_value),
        .o_fault        (out_fault)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    // offer one instruction after a random gap and wait for its transfer
    // called at a falling edge; valid stays up when the next one follows with no gap
    task automatic send_instr(logic [3:0] op, logic imm, logic [7:0] pair, logic [63:0] ext);
        int gap;
        gap = $urandom_range(0, 3);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_op    <= op;
        in_imm   <= imm;
        in_pair  <= pair;
        in_ext   <= ext;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        sb.note_instr(op, imm, pair, ext);
        @(negedge clk);
    endtask

    // random 64-bit operand, biased toward edge values and small shift amounts
    function automatic logic [63:0] pick_value();
        case ($urandom_range(0, 5))
            0: return 64'd0;
            1: return '1;
            2: return 64'($urandom_range(0, 70));
            3: return {1'b1, 63'd0};
            default: return {$urandom(), $urandom()};
        endcase
    endfunction

    // receiver: random stall per result, honoring a long hold-off when requested
    initial begin
        t_alu_result got;
        int wait_n;
        @(negedge clk);
        forever begin
            wait_n = $urandom_range(0, 3);
            if (wait_n > 0 || hold_off) begin
                out_ready <= 1'b0;
                repeat (wait_n) @(negedge clk);
                while (hold_off) @(negedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
            got.wrote = out_wrote;
            got.dest  = out_dest;
            got.value = out_value;
            got.fault = out_fault;
            sb.check_result(got);
            @(negedge clk);
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles > STALL_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin
        logic [3:0] op;
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;

        // directed: load extremes into registers, then every operation and corner
        send_instr(rfa_pkg::OP_OR,  1'b1, 8'h10, '1);                 // r1 = all ones
        send_instr(rfa_pkg::OP_OR,  1'b1, 8'h20, {1'b1, 63'd0});      // r2 = msb only
        send_instr(rfa_pkg::OP_ADD, 1'b1, 8'h30, 64'd7);              // r3 = 7
        send_instr(rfa_pkg::OP_ADD, 1'b0, 8'h41, 64'h2);              // wrap: ones + msb
        send_instr(rfa_pkg::OP_SUB, 1'b0, 8'h50, 64'h1);              // 0 - ones
        send_instr(rfa_pkg::OP_MUL, 1'b0, 8'h61, 64'h1);
        send_instr(rfa_pkg::OP_DIV, 1'b0, 8'h71, 64'h3);
        send_instr(rfa_pkg::OP_DIV, 1'b1, 8'h71, 64'd0);              // divide by zero
        send_instr(rfa_pkg::OP_REM, 1'b0, 8'h81, 64'h3);
        send_instr(rfa_pkg::OP_REM, 1'b0, 8'h81, 64'h0);              // remainder by zero
        send_instr(rfa_pkg::OP_EQ,  1'b0, 8'h91, 64'h1);
        send_instr(rfa_pkg::OP_EQ,  1'b1, 8'h91, 64'd5);
        send_instr(rfa_pkg::OP_AND, 1'b0, 8'ha1, 64'h2);
        send_instr(rfa_pkg::OP_XOR, 1'b1, 8'hb1, 64'h5555_aaaa_0f0f_f0f0);
        send_instr(rfa_pkg::OP_SHR, 1'b1, 8'hc1, 64'd63);
        send_instr(rfa_pkg::OP_SHR, 1'b1, 8'hc1, 64'd64);             // shift too far
        send_instr(rfa_pkg::OP_SHL, 1'b1, 8'hd1, 64'd1);
        send_instr(rfa_pkg::OP_SHL, 1'b0, 8'hd1, 64'hffff_ffff_ffff_fff3); // low nibble index
        send_instr(rfa_pkg::OP_SHL, 1'b1, 8'hd1, '1);
        send_instr(4'd11, 1'b1, 8'hf1, 64'd3);                        // unknown opcodes
        send_instr(4'd15, 1'b0, 8'hff, 64'd1);
        send_instr(rfa_pkg::OP_ADD, 1'b0, 8'hff, 64'hf);

        // pressure: receiver holds off while instructions keep coming
        hold_off = 1'b1;
        fork
            begin
                repeat (300) @(negedge clk);
                hold_off = 1'b0;
            end
            repeat (8) send_instr(rfa_pkg::OP_ADD, 1'b1, 8'($urandom), pick_value());
        join

        for (int n = 0; n < RAND_ITEMS; n++) begin
            op = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(11, 15))
                                              : 4'($urandom_range(0, 10));
            send_instr(op, 1'($urandom), 8'($urandom), pick_value());
        end
        in_valid <= 1'b0;

        while (sb.pending_q.size() != 0) @(posedge clk);
        repeat (100) @(posedge clk);
        if (sb.errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule

// File: register_file_alu_64bit.f
+incdir+rtl
rtl/rfa_pkg.sv
rtl/rfa_ram.sv
rtl/register_file_alu_64bit.sv
rtl/rfa_checker.sv
verif/tb_top.sv
